// ----- rtl/core/mbg_pkg.sv -----
// Shared constants, beat types and grid helpers for the maze backtracker generator.
// Depends on nothing; the top level refers to it by scoped names.
package mbg_pkg;

	localparam int GRID_ROWS   = 31;
	localparam int GRID_COLS   = 41;
	localparam int ROW_CELLS   = (GRID_ROWS - 1) / 2 - 1;
	localparam int COL_CELLS   = (GRID_COLS - 1) / 2 - 1;
	localparam int TOTAL_CELLS = ROW_CELLS * COL_CELLS;
	localparam int STACK_DEPTH = TOTAL_CELLS;
	localparam int ROW_MAX     = 2 * ROW_CELLS;
	localparam int COL_MAX     = 2 * COL_CELLS;
	localparam int GRID_DEPTH  = GRID_ROWS * GRID_COLS;
	localparam int GRID_AW     = $clog2(GRID_DEPTH);
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	localparam int ENTRY_ADDR  = 2 * GRID_COLS + 1;
	localparam int EXIT_ADDR   = ROW_MAX * GRID_COLS + COL_MAX + 1;

	// field widths fixed by the beat formats
	localparam int OP_W   = 2;
	localparam int SROW_W = 4;
	localparam int SCOL_W = 5;
	localparam int DIR_W  = 2;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 6;
	localparam int CNT_W  = 9;

	localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW    = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	localparam logic [DIR_W-1:0] DIR_ROW_PLUS  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_ROW_MINUS = 2'd1;
	localparam logic [DIR_W-1:0] DIR_COL_PLUS  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_COL_MINUS = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SROW_W-1:0] start_cell_row;
		logic [SCOL_W-1:0] start_cell_col;
		logic [DIR_W-1:0]  direction;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} req_t;

	typedef struct packed {
		logic             accepted;
		logic [ROW_W-1:0] cur_row;
		logic [COL_W-1:0] cur_col;
		logic [CNT_W-1:0] visited_count;
		logic             done_res;
		logic             cell_open;
	} rsp_t;

	// linear grid address, row major
	function automatic logic [GRID_AW-1:0] grid_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		grid_addr = GRID_AW'(row) * GRID_AW'(GRID_COLS) + GRID_AW'(col);
	endfunction

	// row coordinate after a step of amt along dir
	function automatic logic [ROW_W-1:0] move_row(input logic [ROW_W-1:0] row,
		input logic [DIR_W-1:0] dir, input logic [ROW_W-1:0] amt);
		unique case (dir)
			DIR_ROW_PLUS:  move_row = row + amt;
			DIR_ROW_MINUS: move_row = row - amt;
			default:       move_row = row;
		endcase
	endfunction

	// column coordinate after a step of amt along dir
	function automatic logic [COL_W-1:0] move_col(input logic [COL_W-1:0] col,
		input logic [DIR_W-1:0] dir, input logic [COL_W-1:0] amt);
		unique case (dir)
			DIR_COL_PLUS:  move_col = col + amt;
			DIR_COL_MINUS: move_col = col - amt;
			default:       move_col = col;
		endcase
	endfunction

	// reverse direction: codes pair up in their low bit
	function automatic logic [DIR_W-1:0] opposite_dir(input logic [DIR_W-1:0] dir);
		opposite_dir = dir ^ DIR_ROW_MINUS;
	endfunction

endpackage

// ----- rtl/core/maze_backtracker_generator.sv -----
// Top level of the maze backtracker generator: sequencer, grid and move stack.
// Depends on mbg_pkg and mbg_ram.
//
// Depth-first maze carver. The wall grid (one bit per position, 1 = wall) lives in
// two identical copies of a 1271-entry RAM so that two neighbours can be probed per
// cycle; the moves taken live in a 266-entry stack RAM. Both RAMs have a registered
// read port. A beat is taken when start is high and busy is low; exactly one result
// beat follows each command, shown on rsp for one cycle with rsp_strobe high, and the
// receiver cannot hold it off. Busy is high after reset while the grid is swept to
// its reset pattern (border open, interior walled); no command is taken during that
// sweep. A restart runs the same sweep, with the start cell and both openings carved
// as it passes them. A draw that carves probes the four neighbours, writes the
// passage and then the cell; each move popped while backtracking adds a stack RAM
// read and a re-probe of four neighbours over the two grid read ports. A read looks
// up one grid bit; a read outside the grid, a draw on a finished maze and an unknown
// operation are answered straight from idle. No new command is taken until the
// result beat of the last one is on rsp.
// Grid writes for a carve go through the single write port, the passage and then,
// in the next cycle, the cell; the sequencer never reads the grid while it writes it.
module maze_backtracker_generator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mbg_pkg::req_t req,
	output mbg_pkg::rsp_t rsp,
	output logic          rsp_strobe
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PROBE = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_POP   = 3'd4;
	localparam logic [2:0] S_CARVE = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;

	// control state
	logic [2:0]                     state_q, state_d;
	logic                           restart_q, restart_d;
	logic [mbg_pkg::GRID_AW-1:0]    clr_addr_q, clr_addr_d;
	logic [mbg_pkg::ROW_W-1:0]      clr_row_q, clr_row_d;
	logic [mbg_pkg::COL_W-1:0]      clr_col_q, clr_col_d;
	logic                           pidx_q, pidx_d;
	logic                           pair_vld_s1, pair_vld_d;
	logic                           pair_idx_s1, pair_idx_d;
	logic [mbg_pkg::ROW_W-1:0]      walker_row_q, walker_row_d;
	logic [mbg_pkg::COL_W-1:0]      walker_col_q, walker_col_d;
	logic [mbg_pkg::SP_W-1:0]       sp_q, sp_d;
	logic [mbg_pkg::CNT_W-1:0]      carved_q, carved_d;
	logic                           rsp_strobe_q;

	// payload registers
	logic [mbg_pkg::DIR_W-1:0]      dir_q, dir_d;
	logic [1:0]                     wall_q;
	mbg_pkg::rsp_t                  rsp_q, rsp_d;

	// memory ports
	logic                           grid_we;
	logic [mbg_pkg::GRID_AW-1:0]    grid_waddr;
	logic                           grid_wdata;
	logic [mbg_pkg::GRID_AW-1:0]    grid_raddr_a, grid_raddr_b;
	logic                           grid_rd_a, grid_rd_b;
	logic                           stack_we;
	logic [mbg_pkg::STACK_AW-1:0]   stack_waddr, stack_raddr;
	logic [mbg_pkg::DIR_W-1:0]      stack_rd;

	// helpers
	logic [mbg_pkg::GRID_AW-1:0]    nb_addr [4];
	logic [3:0]                     guard;
	logic [3:0]                     walls;
	logic [mbg_pkg::GRID_AW-1:0]    start_addr;
	logic [mbg_pkg::GRID_AW-1:0]    pass_addr;
	logic                           border;
	logic                           special;
	logic [mbg_pkg::SROW_W-1:0]     srow_clamp;
	logic [mbg_pkg::SCOL_W-1:0]     scol_clamp;
	logic                           read_in_grid;
	logic                           emit;
	logic                           acc;
	logic                           cell_open_d;

	// Two copies of the grid, written together, give two read ports.
	mbg_ram #(.DEPTH(mbg_pkg::GRID_DEPTH), .WIDTH(1)) u_grid_a (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.raddr (grid_raddr_a),
		.rdata (grid_rd_a)
	);

	mbg_ram #(.DEPTH(mbg_pkg::GRID_DEPTH), .WIDTH(1)) u_grid_b (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.raddr (grid_raddr_b),
		.rdata (grid_rd_b)
	);

	mbg_ram #(.DEPTH(mbg_pkg::STACK_DEPTH), .WIDTH(mbg_pkg::DIR_W)) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (dir_q),
		.raddr (stack_raddr),
		.rdata (stack_rd)
	);

	// Neighbour cells two steps away, indexed by direction code.
	always_comb begin
		for (int d = 0; d < 4; d++) begin
			nb_addr[d] = mbg_pkg::grid_addr(
				mbg_pkg::move_row(walker_row_q, 2'(d), mbg_pkg::ROW_W'(2)),
				mbg_pkg::move_col(walker_col_q, 2'(d), mbg_pkg::COL_W'(2)));
		end
	end

	// A neighbour only counts when it stays inside the cell lattice.
	assign guard[mbg_pkg::DIR_ROW_PLUS]  = walker_row_q < mbg_pkg::ROW_W'(mbg_pkg::ROW_MAX);
	assign guard[mbg_pkg::DIR_ROW_MINUS] = walker_row_q > mbg_pkg::ROW_W'(2);
	assign guard[mbg_pkg::DIR_COL_PLUS]  = walker_col_q < mbg_pkg::COL_W'(mbg_pkg::COL_MAX);
	assign guard[mbg_pkg::DIR_COL_MINUS] = walker_col_q > mbg_pkg::COL_W'(2);

	// First pair captured in wall_q, second pair straight off the read ports.
	assign walls = {grid_rd_b, grid_rd_a, wall_q} & guard;

	assign pass_addr = mbg_pkg::grid_addr(
		mbg_pkg::move_row(walker_row_q, dir_q, mbg_pkg::ROW_W'(1)),
		mbg_pkg::move_col(walker_col_q, dir_q, mbg_pkg::COL_W'(1)));

	// Sweep pattern: border open, interior walled, restart openings carved.
	assign start_addr = mbg_pkg::grid_addr(walker_row_q, walker_col_q);
	assign border     = (clr_row_q == '0)
		|| (clr_row_q == mbg_pkg::ROW_W'(mbg_pkg::GRID_ROWS - 1))
		|| (clr_col_q == '0)
		|| (clr_col_q == mbg_pkg::COL_W'(mbg_pkg::GRID_COLS - 1));
	assign special    = (clr_addr_q == start_addr)
		|| (clr_addr_q == mbg_pkg::GRID_AW'(mbg_pkg::ENTRY_ADDR))
		|| (clr_addr_q == mbg_pkg::GRID_AW'(mbg_pkg::EXIT_ADDR));

	// Clamp the start cell indices into the lattice.
	always_comb begin
		if (req.start_cell_row == '0) begin
			srow_clamp = mbg_pkg::SROW_W'(1);
		end else if (req.start_cell_row > mbg_pkg::SROW_W'(mbg_pkg::ROW_CELLS)) begin
			srow_clamp = mbg_pkg::SROW_W'(mbg_pkg::ROW_CELLS);
		end else begin
			srow_clamp = req.start_cell_row;
		end
		if (req.start_cell_col == '0) begin
			scol_clamp = mbg_pkg::SCOL_W'(1);
		end else if (req.start_cell_col > mbg_pkg::SCOL_W'(mbg_pkg::COL_CELLS)) begin
			scol_clamp = mbg_pkg::SCOL_W'(mbg_pkg::COL_CELLS);
		end else begin
			scol_clamp = req.start_cell_col;
		end
	end

	assign read_in_grid = (req.read_row < mbg_pkg::ROW_W'(mbg_pkg::GRID_ROWS))
		&& (req.read_col < mbg_pkg::COL_W'(mbg_pkg::GRID_COLS));

	// Top of stack; hold at entry zero when empty.
	assign stack_raddr = (sp_q == '0) ? '0 : sp_q[mbg_pkg::STACK_AW-1:0] - 1'b1;
	assign stack_waddr = sp_q[mbg_pkg::STACK_AW-1:0];

	// Sequencer
	always_comb begin
		state_d      = state_q;
		restart_d    = restart_q;
		clr_addr_d   = clr_addr_q;
		clr_row_d    = clr_row_q;
		clr_col_d    = clr_col_q;
		pidx_d       = pidx_q;
		pair_vld_d   = 1'b0;
		pair_idx_d   = pair_idx_s1;
		dir_d        = dir_q;
		walker_row_d = walker_row_q;
		walker_col_d = walker_col_q;
		sp_d         = sp_q;
		carved_d     = carved_q;
		grid_we      = 1'b0;
		grid_waddr   = clr_addr_q;
		grid_wdata   = 1'b0;
		grid_raddr_a = nb_addr[mbg_pkg::DIR_ROW_PLUS];
		grid_raddr_b = nb_addr[mbg_pkg::DIR_ROW_MINUS];
		stack_we     = 1'b0;
		emit         = 1'b0;
		acc          = 1'b0;
		cell_open_d  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = clr_addr_q;
				grid_wdata = ~(border | (restart_q & special));
				if (clr_addr_q == mbg_pkg::GRID_AW'(mbg_pkg::GRID_DEPTH - 1)) begin
					state_d   = S_IDLE;
					emit      = restart_q;
					restart_d = 1'b0;
				end else begin
					clr_addr_d = clr_addr_q + 1'b1;
					if (clr_col_q == mbg_pkg::COL_W'(mbg_pkg::GRID_COLS - 1)) begin
						clr_col_d = '0;
						clr_row_d = clr_row_q + 1'b1;
					end else begin
						clr_col_d = clr_col_q + 1'b1;
					end
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (req.operation)
						mbg_pkg::OP_RESTART: begin
							walker_row_d = {srow_clamp, 1'b0};
							walker_col_d = {scol_clamp, 1'b0};
							sp_d         = '0;
							carved_d     = mbg_pkg::CNT_W'(1);
							restart_d    = 1'b1;
							clr_addr_d   = '0;
							clr_row_d    = '0;
							clr_col_d    = '0;
							state_d      = S_CLEAR;
						end
						mbg_pkg::OP_DRAW: begin
							if (carved_q >= mbg_pkg::CNT_W'(mbg_pkg::TOTAL_CELLS)) begin
								emit = 1'b1;
							end else begin
								// first neighbour pair goes out with the accept
								dir_d      = req.direction;
								pair_vld_d = 1'b1;
								pair_idx_d = 1'b0;
								pidx_d     = 1'b1;
								state_d    = S_PROBE;
							end
						end
						mbg_pkg::OP_READ: begin
							if (read_in_grid) begin
								grid_raddr_a = mbg_pkg::grid_addr(req.read_row, req.read_col);
								state_d      = S_READ;
							end else begin
								emit = 1'b1;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_PROBE: begin
				pair_vld_d = 1'b1;
				if (!pidx_q) begin
					pair_idx_d = 1'b0;
					pidx_d     = 1'b1;
				end else begin
					grid_raddr_a = nb_addr[mbg_pkg::DIR_COL_PLUS];
					grid_raddr_b = nb_addr[mbg_pkg::DIR_COL_MINUS];
					pair_idx_d   = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				if (walls == '0 && sp_q != '0) begin
					// dead end: drop one move, stack read is already addressed
					sp_d    = sp_q - 1'b1;
					state_d = S_POP;
				end else if (walls[dir_q] && sp_q < mbg_pkg::SP_W'(mbg_pkg::STACK_DEPTH)) begin
					stack_we   = 1'b1;
					sp_d       = sp_q + 1'b1;
					grid_we    = 1'b1;
					grid_waddr = pass_addr;
					state_d    = S_CARVE;
				end else begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				walker_row_d = mbg_pkg::move_row(walker_row_q, mbg_pkg::opposite_dir(stack_rd),
					mbg_pkg::ROW_W'(2));
				walker_col_d = mbg_pkg::move_col(walker_col_q, mbg_pkg::opposite_dir(stack_rd),
					mbg_pkg::COL_W'(2));
				pidx_d       = 1'b0;
				state_d      = S_PROBE;
			end
			S_CARVE: begin
				grid_we      = 1'b1;
				grid_waddr   = nb_addr[dir_q];
				walker_row_d = mbg_pkg::move_row(walker_row_q, dir_q, mbg_pkg::ROW_W'(2));
				walker_col_d = mbg_pkg::move_col(walker_col_q, dir_q, mbg_pkg::COL_W'(2));
				carved_d     = carved_q + 1'b1;
				emit         = 1'b1;
				acc          = 1'b1;
				state_d      = S_IDLE;
			end
			S_READ: begin
				cell_open_d = ~grid_rd_a;
				emit        = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result beat reflects the state after this command.
	always_comb begin
		rsp_d.accepted      = acc;
		rsp_d.cur_row       = walker_row_d;
		rsp_d.cur_col       = walker_col_d;
		rsp_d.visited_count = carved_d;
		rsp_d.done_res      = carved_d >= mbg_pkg::CNT_W'(mbg_pkg::TOTAL_CELLS);
		rsp_d.cell_open     = cell_open_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			restart_q    <= 1'b0;
			clr_addr_q   <= '0;
			clr_row_q    <= '0;
			clr_col_q    <= '0;
			pidx_q       <= 1'b0;
			pair_vld_s1  <= 1'b0;
			pair_idx_s1  <= 1'b0;
			walker_row_q <= mbg_pkg::ROW_W'(2);
			walker_col_q <= mbg_pkg::COL_W'(2);
			sp_q         <= '0;
			carved_q     <= '0;
			rsp_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			restart_q    <= restart_d;
			clr_addr_q   <= clr_addr_d;
			clr_row_q    <= clr_row_d;
			clr_col_q    <= clr_col_d;
			pidx_q       <= pidx_d;
			pair_vld_s1  <= pair_vld_d;
			pair_idx_s1  <= pair_idx_d;
			walker_row_q <= walker_row_d;
			walker_col_q <= walker_col_d;
			sp_q         <= sp_d;
			carved_q     <= carved_d;
			rsp_strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		dir_q <= dir_d;
		// hold the first neighbour pair until the second arrives
		if (pair_vld_s1 && !pair_idx_s1) begin
			wall_q <= {grid_rd_b, grid_rd_a};
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy       = state_q != S_IDLE;
	assign rsp        = rsp_q;
	assign rsp_strobe = rsp_strobe_q;

`ifndef SYNTHESIS
	// the decision cycle must see the second neighbour pair on the read ports
	a_eval_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> pair_vld_s1 && pair_idx_s1)
		else $error("decision taken without second probe pair");

	// a result beat always leaves the block ready for the next command
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe_q |-> state_q == S_IDLE)
		else $error("result beat while sequencer busy");

	// every stacked move carved a cell, so the stack never outgrows the count;
	// the push leads the count by the carve cycle
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CARVE |-> sp_q <= carved_q)
		else $error("stack deeper than carved cell count");

	// a push goes with the passage write
	a_push_carve: assert property (@(posedge clk) disable iff (!arst_n)
		stack_we |-> state_q == S_EVAL && grid_we && grid_wdata == 1'b0)
		else $error("stack push without passage carve");

	// carving the cell advances the count by one
	a_carve_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CARVE |=> carved_q == mbg_pkg::CNT_W'($past(carved_q) + 1'b1))
		else $error("carve did not advance the cell count");
`endif

endmodule

// ----- rtl/core/mbg_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the wall grid copies and the move stack.
module mbg_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
